// ===== rtl/l1_meeting_point_select_assert.svh =====
// assertion macros shared by the meeting point select rtl
`ifndef L1_MEETING_POINT_SELECT_ASSERT_SVH
`define L1_MEETING_POINT_SELECT_ASSERT_SVH

// same-cycle implication
`define MPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mps assertion failed");

// next-cycle implication
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mps assertion failed");

`endif

// ===== rtl/mps_pkg.sv =====
// shared constants and types for the meeting point select block
package mps_pkg;

  localparam int unsigned DEF_MAX_POINTS = 16;
  localparam int unsigned POS_W          = 8;
  localparam int unsigned COST_W         = 12;
  localparam int unsigned JOB_Q_DEPTH    = 2;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [COST_W-1:0] cost_t;

  localparam cost_t COST_MAX = '1;

endpackage

// ===== rtl/mps_ifs.sv =====
// point and result channel interfaces
interface mps_in_if;
  logic          valid;
  logic          ready;
  mps_pkg::pos_t position;
  logic          last_point;

  modport source (output valid, position, last_point, input ready);
  modport sink   (input valid, position, last_point, output ready);
endinterface

interface mps_out_if;
  logic           valid;
  logic           ready;
  mps_pkg::pos_t  best_position;
  mps_pkg::pos_t  mean_position;
  mps_pkg::pos_t  median_position;
  mps_pkg::cost_t mean_cost;
  mps_pkg::cost_t median_cost;

  modport source (output valid, best_position, mean_position, median_position,
                  mean_cost, median_cost, input ready);
  modport sink   (input valid, best_position, mean_position, median_position,
                  mean_cost, median_cost, output ready);
endinterface

// ===== rtl/mps_front.sv =====
// front end: accepts points, fills the store, counts and sums, issues jobs
`include "l1_meeting_point_select_assert.svh"

module mps_front #(
  parameter int unsigned MAX_POINTS = mps_pkg::DEF_MAX_POINTS,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned SW = mps_pkg::POS_W + CW,
  localparam int unsigned JW = CW + SW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mps_in_if.sink        points_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output mps_pkg::pos_t wr_data_o,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output logic [JW-1:0] job_o,
  input  logic          release_i
);

  logic [CW-1:0] count_q;
  logic [SW-1:0] sum_q;
  logic          busy_q;
  logic          full;
  logic          accept;
  logic [CW-1:0] count_d;
  logic [SW-1:0] sum_d;

  assign full           = (count_q == CW'(MAX_POINTS));
  assign points_i.ready = !busy_q && job_ready_i;
  assign accept         = points_i.valid && points_i.ready;

  assign wr_en_o   = accept && !full;
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = points_i.position;

  // a point beyond the store is dropped
  assign count_d = full ? count_q : count_q + CW'(1);
  assign sum_d   = full ? sum_q : sum_q + SW'(points_i.position);

  assign job_valid_o = accept && points_i.last_point;
  assign job_o       = {count_d, sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (release_i) begin
        busy_q <= 1'b0;
      end
      if (accept) begin
        if (points_i.last_point) begin
          count_q <= '0;
          sum_q   <= '0;
          busy_q  <= 1'b1;
        end else begin
          count_q <= count_d;
          sum_q   <= sum_d;
        end
      end
    end
  end

  `MPS_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_POINTS))
  `MPS_ASSERT_NEXT(a_hold_after_last, clk_i, rst_ni, job_valid_o, !points_i.ready)

endmodule

// ===== rtl/mps_job_q.sv =====
// short job queue between front and back
`include "l1_meeting_point_select_assert.svh"

module mps_job_q #(
  parameter int unsigned W = 8,
  localparam int unsigned D  = mps_pkg::JOB_Q_DEPTH,
  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1,
  localparam int unsigned NW = $clog2(D + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0]  slot_q [D];
  logic [PW-1:0] wptr_q;
  logic [PW-1:0] rptr_q;
  logic [NW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign ready_o = (cnt_q != NW'(D));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rptr_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(D - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(D - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  `MPS_ASSERT_NEXT(a_q_push_count, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + NW'(1))

endmodule

// ===== rtl/mps_back.sv =====
// back end: store, mean divider, median selection, cost pass, result register
`include "l1_meeting_point_select_assert.svh"

module mps_back #(
  parameter int unsigned MAX_POINTS = mps_pkg::DEF_MAX_POINTS,
  localparam int unsigned PW  = mps_pkg::POS_W,
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned SW  = PW + CW,
  localparam int unsigned JW  = CW + SW,
  localparam int unsigned STW = $clog2(SW),
  localparam int unsigned CTW = (PW + CW > mps_pkg::COST_W) ? PW + CW : mps_pkg::COST_W + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  mps_pkg::pos_t wr_data_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  logic [JW-1:0] job_i,
  output logic          release_o,
  mps_out_if.source     result_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_COST = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  mps_pkg::pos_t  mem_q [MAX_POINTS];
  mps_pkg::pos_t  rd_a_q;
  mps_pkg::pos_t  rd_b_q;

  logic [2:0]     state_q;
  logic [CW-1:0]  n_q;
  logic [SW-1:0]  qd_q;
  logic [CW-1:0]  r_q;
  logic [STW-1:0] step_q;
  logic [AW-1:0]  i_q;
  logic [AW-1:0]  j_q;
  logic           ph_q;
  logic [CW-1:0]  less_q;
  logic [CW-1:0]  leq_q;
  mps_pkg::pos_t  lo_q;
  mps_pkg::pos_t  hi_q;
  logic [CTW-1:0] mc_q;
  logic [CTW-1:0] dc_q;

  logic           out_valid_q;
  mps_pkg::pos_t  best_q;
  mps_pkg::pos_t  mean_out_q;
  mps_pkg::pos_t  med_out_q;
  mps_pkg::cost_t mc_out_q;
  mps_pkg::cost_t dc_out_q;

  logic [CW:0]    trial;
  logic [CW:0]    diff;
  logic           ge;
  logic [CW-1:0]  less_f;
  logic [CW-1:0]  leq_f;
  logic [CW-1:0]  k1;
  logic [CW-1:0]  k0;
  logic           i_last;
  logic           j_last;
  mps_pkg::pos_t  mean;
  logic [PW:0]    mid_sum;
  mps_pkg::pos_t  median;
  mps_pkg::pos_t  dist_mean;
  mps_pkg::pos_t  dist_med;
  mps_pkg::cost_t mc_sat;
  mps_pkg::cost_t dc_sat;
  logic           out_free;

  // store, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_q[i_q];
    rd_b_q <= mem_q[j_q];
  end

  // restoring divider step
  assign trial = {r_q, qd_q[SW-1]};
  assign ge    = (trial >= {1'b0, n_q});
  assign diff  = trial - {1'b0, n_q};

  // rank counts of element i
  assign less_f = less_q + CW'(rd_b_q < rd_a_q);
  assign leq_f  = leq_q + CW'(rd_b_q <= rd_a_q);
  assign k1     = n_q >> 1;
  assign k0     = k1 - CW'(1);
  assign i_last = (CW'(i_q) == n_q - CW'(1));
  assign j_last = (CW'(j_q) == n_q - CW'(1));

  assign mean    = qd_q[PW-1:0];
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign median  = n_q[0] ? hi_q : mid_sum[PW:1];

  assign dist_mean = (rd_b_q >= mean) ? rd_b_q - mean : mean - rd_b_q;
  assign dist_med  = (rd_b_q >= median) ? rd_b_q - median : median - rd_b_q;

  assign mc_sat = (mc_q > CTW'(mps_pkg::COST_MAX)) ? mps_pkg::COST_MAX
                                                   : mc_q[mps_pkg::COST_W-1:0];
  assign dc_sat = (dc_q > CTW'(mps_pkg::COST_MAX)) ? mps_pkg::COST_MAX
                                                   : dc_q[mps_pkg::COST_W-1:0];

  assign out_free    = !out_valid_q || result_o.ready;
  assign job_ready_o = (state_q == ST_IDLE);
  assign release_o   = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      step_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ph_q    <= 1'b0;
      less_q  <= '0;
      leq_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            n_q     <= job_i[JW-1:SW];
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          step_q <= step_q + STW'(1);
          if (step_q == STW'(SW - 1)) begin
            i_q     <= '0;
            j_q     <= '0;
            ph_q    <= 1'b0;
            less_q  <= '0;
            leq_q   <= '0;
            state_q <= ST_SEL;
          end
        end
        ST_SEL: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (j_last) begin
              j_q    <= '0;
              less_q <= '0;
              leq_q  <= '0;
              if (i_last) begin
                state_q <= ST_COST;
              end else begin
                i_q <= i_q + AW'(1);
              end
            end else begin
              j_q    <= j_q + AW'(1);
              less_q <= less_f;
              leq_q  <= leq_f;
            end
          end
        end
        ST_COST: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (j_last) begin
              state_q <= ST_DONE;
            end else begin
              j_q <= j_q + AW'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      qd_q <= job_i[SW-1:0];
      r_q  <= '0;
    end
    if (state_q == ST_DIV) begin
      r_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
      qd_q <= {qd_q[SW-2:0], ge};
    end
    if (state_q == ST_SEL && ph_q && j_last) begin
      if (k1 >= less_f && k1 < leq_f) begin
        hi_q <= rd_a_q;
      end
      if (!n_q[0] && k0 >= less_f && k0 < leq_f) begin
        lo_q <= rd_a_q;
      end
      mc_q <= '0;
      dc_q <= '0;
    end
    if (state_q == ST_COST && ph_q) begin
      mc_q <= mc_q + CTW'(dist_mean);
      dc_q <= dc_q + CTW'(dist_med);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (release_o) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (release_o) begin
      best_q     <= (dc_sat < mc_sat) ? median : mean;
      mean_out_q <= mean;
      med_out_q  <= median;
      mc_out_q   <= mc_sat;
      dc_out_q   <= dc_sat;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.best_position   = best_q;
  assign result_o.mean_position   = mean_out_q;
  assign result_o.median_position = med_out_q;
  assign result_o.mean_cost       = mc_out_q;
  assign result_o.median_cost     = dc_out_q;

  `MPS_ASSERT_IMPL(a_job_nonzero, clk_i, rst_ni, state_q != ST_IDLE, n_q != '0)
  `MPS_ASSERT_NEXT(a_release_loads, clk_i, rst_ni, release_o, result_o.valid && state_q == ST_IDLE)
  `MPS_ASSERT_IMPL(a_best_is_candidate, clk_i, rst_ni, result_o.valid, (result_o.best_position == result_o.median_position) || (result_o.best_position == result_o.mean_position))

endmodule

// ===== rtl/l1_meeting_point_select.sv =====
// top level of the meeting point select block
// loading: one point per cycle unless a set is in progress or the job queue is full
// dropped points are still accepted; after the last point the back end runs through
//   SW = 8 + clog2(MAX_POINTS+1) divider steps, n*n pairwise rank compares, n cost steps
// the next set loads once the result moves to the output register, which may still wait
// reset is asynchronous active low: clears counts, sequencer and result valid
// store contents are undefined after reset and are read only where written
module l1_meeting_point_select #(
  parameter int unsigned MAX_POINTS = mps_pkg::DEF_MAX_POINTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mps_in_if.sink    points_i,
  mps_out_if.source result_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned SW = mps_pkg::POS_W + CW;
  localparam int unsigned JW = CW + SW;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  mps_pkg::pos_t wr_data;
  logic          fj_valid;
  logic          fj_ready;
  logic [JW-1:0] fj_data;
  logic          bj_valid;
  logic          bj_ready;
  logic [JW-1:0] bj_data;
  logic          store_release;

  mps_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .points_i    (points_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_data),
    .release_i   (store_release)
  );

  mps_job_q #(
    .W (JW)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fj_valid),
    .ready_o (fj_ready),
    .data_i  (fj_data),
    .valid_o (bj_valid),
    .ready_i (bj_ready),
    .data_o  (bj_data)
  );

  mps_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .release_o   (store_release),
    .result_o    (result_o)
  );

endmodule

// ===== sim/l1_meeting_point_select_tb.sv =====
// testbench for l1_meeting_point_select: random point sets checked against a mean/median predictor
`timescale 1ns / 1ps

module l1_meeting_point_select_tb;

  localparam int unsigned MAX_POINTS  = mps_pkg::DEF_MAX_POINTS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 700;

  typedef struct packed {
    mps_pkg::pos_t  best_position;
    mps_pkg::pos_t  mean_position;
    mps_pkg::pos_t  median_position;
    mps_pkg::cost_t mean_cost;
    mps_pkg::cost_t median_cost;
  } meeting_t;

  class meeting_point_scoreboard;
    mps_pkg::pos_t held[$];
    int unsigned   held_sum;
    meeting_t      meetings_due[$];
    int unsigned   errors;

    function mps_pkg::cost_t distance_total(mps_pkg::pos_t pts[$], int unsigned at);
      int unsigned total;
      total = 0;
      foreach (pts[k]) begin
        total += (pts[k] > at) ? (pts[k] - at) : (at - pts[k]);
      end
      return (total > mps_pkg::COST_MAX) ? mps_pkg::COST_MAX : mps_pkg::cost_t'(total);
    endfunction

    function meeting_t choose_meeting();
      mps_pkg::pos_t ordered[$];
      int unsigned   n;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   mean;
      int unsigned   median;
      meeting_t      m;
      ordered = held;
      ordered.sort();
      n = ordered.size();
      mean = held_sum / n;
      if (n % 2 == 0) begin
        lo = ordered[n/2-1];
        hi = ordered[n/2];
        median = (lo + hi) / 2;
      end else begin
        median = ordered[n/2];
      end
      m.mean_position   = mps_pkg::pos_t'(mean);
      m.median_position = mps_pkg::pos_t'(median);
      m.mean_cost       = distance_total(ordered, mean);
      m.median_cost     = distance_total(ordered, median);
      m.best_position   = (m.median_cost < m.mean_cost) ? m.median_position : m.mean_position;
      return m;
    endfunction

    function void note_point(mps_pkg::pos_t p, logic last);
      if (held.size() < MAX_POINTS) begin
        held.push_back(p);
        held_sum += p;
      end
      if (last) begin
        meetings_due.push_back(choose_meeting());
        held.delete();
        held_sum = 0;
      end
    endfunction

    function void check_result(meeting_t got);
      meeting_t want;
      if (meetings_due.size() == 0) begin
        $error("unexpected result: best_position %0d", got.best_position);
        errors++;
        return;
      end
      want = meetings_due.pop_front();
      if (got.best_position !== want.best_position) begin
        $error("best_position expected %0d got %0d", want.best_position, got.best_position);
        errors++;
      end
      if (got.mean_position !== want.mean_position) begin
        $error("mean_position expected %0d got %0d", want.mean_position, got.mean_position);
        errors++;
      end
      if (got.median_position !== want.median_position) begin
        $error("median_position expected %0d got %0d", want.median_position,
               got.median_position);
        errors++;
      end
      if (got.mean_cost !== want.mean_cost) begin
        $error("mean_cost expected %0d got %0d", want.mean_cost, got.mean_cost);
        errors++;
      end
      if (got.median_cost !== want.median_cost) begin
        $error("median_cost expected %0d got %0d", want.median_cost, got.median_cost);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mps_in_if  points();
  mps_out_if results();

  l1_meeting_point_select #(
    .MAX_POINTS(MAX_POINTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .points_i(points),
    .result_o(results)
  );

  meeting_point_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned items_sent;
  bit          valid_low;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && results.valid && results.ready) begin
      sb.check_result({results.best_position, results.mean_position,
                       results.median_position, results.mean_cost, results.median_cost});
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("l1_meeting_point_select_tb: errors");
      $finish;
    end
  end

  task automatic send_point(input mps_pkg::pos_t p, input logic last);
    int unsigned gap;
    points.valid      <= 1'b1;
    points.position   <= p;
    points.last_point <= last;
    valid_low = 1'b0;
    do @(posedge clk_i); while (!points.ready);
    sb.note_point(p, last);
    items_sent++;
    gap = 0;
    while (send_idle_pct != 0 && gap < 10 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      points.valid <= 1'b0;
      valid_low = 1'b1;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every pending meeting has come back
  task automatic drain();
    if (!valid_low) begin
      points.valid <= 1'b0;
      valid_low = 1'b1;
    end
    do @(posedge clk_i); while (sb.meetings_due.size() != 0);
  endtask

  task automatic send_random_set();
    int unsigned   n;
    int unsigned   sel;
    int unsigned   mode;
    mps_pkg::pos_t base;
    mps_pkg::pos_t p;
    sel = $urandom_range(99);
    if (sel < 60) n = $urandom_range(6, 1);
    else if (sel < 90) n = $urandom_range(MAX_POINTS, 7);
    else n = $urandom_range(MAX_POINTS + 4, MAX_POINTS + 1);
    mode = $urandom_range(3);
    base = mps_pkg::pos_t'($urandom_range(255));
    for (int unsigned k = 0; k < n; k++) begin
      case (mode)
        1: begin
          p = base + mps_pkg::pos_t'($urandom_range(7));
        end
        2: begin
          p = $urandom_range(1) ? 8'hff : 8'h00;
        end
        default: begin
          p = mps_pkg::pos_t'($urandom_range(255));
        end
      endcase
      send_point(p, k == n - 1);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    points.valid      = 1'b0;
    points.position   = '0;
    points.last_point = 1'b0;
    results.ready     = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    cycle_count       = 0;
    items_sent        = 0;
    valid_low         = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single points at both ends, an even pair, a set where the median wins
    send_point(8'h00, 1'b1);
    send_point(8'hff, 1'b1);
    send_point(8'h00, 1'b0);
    send_point(8'hff, 1'b1);
    send_point(8'h00, 1'b0);
    send_point(8'h00, 1'b0);
    send_point(8'hff, 1'b1);
    // full store in descending order, then dropped points, the last one closing the set
    for (int unsigned k = 0; k < MAX_POINTS; k++) begin
      send_point(mps_pkg::pos_t'((MAX_POINTS - 1 - k) * 17), 1'b0);
    end
    send_point(8'd200, 1'b0);
    send_point(8'd1, 1'b1);
    drain();

    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 52;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 52;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct     = 32;
        end
      endcase
      items_sent = 0;
      while (items_sent < 104) send_random_set();
      drain();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (sb.meetings_due.size() != 0) begin
      $error("%0d results never arrived", sb.meetings_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("l1_meeting_point_select_tb: clean");
    end else begin
      $display("l1_meeting_point_select_tb: errors");
    end
    $finish;
  end

endmodule
